[hdl/icy_pkg.sv]
// icy_pkg: shared types, codes and the key text for the ICY metadata demux.
// No dependencies; used by icy_parse, icy_metadata_demux_top and icy_checker.

package icy_pkg;

	localparam int unsigned IntervalWidth = 24;
	localparam int unsigned RemainWidth   = 12;
	localparam int unsigned MatchWidth    = 4;
	localparam int unsigned KeyLen        = 13;

	typedef logic [IntervalWidth-1:0] interval_t;

	// Stream phase
	typedef enum logic [1:0] {
		PH_AUDIO  = 2'd0,
		PH_LENGTH = 2'd1,
		PH_META   = 2'd2
	} phase_t;

	// Title scanner phase
	typedef enum logic [1:0] {
		TP_SEARCH = 2'd0,
		TP_EMIT   = 2'd1,
		TP_DONE   = 2'd2
	} title_phase_t;

	// Result kind codes as seen on out_kind
	typedef enum logic [1:0] {
		K_AUDIO = 2'd0,
		K_TITLE = 2'd1,
		K_MARK  = 2'd2
	} kind_t;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChQuote = 8'h27;
	localparam logic [7:0] ChSemi  = 8'h3b;
	localparam logic [7:0] ChS     = 8'h53;

	// Demux state without the title character count (its width follows TITLE_MAX)
	typedef struct packed {
		interval_t             audio_countdown;
		phase_t                phase;
		logic [RemainWidth-1:0] meta_remaining;
		logic [MatchWidth-1:0] match_index;
		title_phase_t          title_phase;
		logic                  quote_pending;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} result_t;

	// Up to three results caused by one stream byte, entry 0 first
	typedef struct packed {
		result_t [2:0] res;
		logic [1:0]    count;
	} step_out_t;

	// Characters of StreamTitle='
	function automatic logic [7:0] key_char(input logic [MatchWidth-1:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h53; // S
			4'd1:    c = 8'h74; // t
			4'd2:    c = 8'h72; // r
			4'd3:    c = 8'h65; // e
			4'd4:    c = 8'h61; // a
			4'd5:    c = 8'h6d; // m
			4'd6:    c = 8'h54; // T
			4'd7:    c = 8'h69; // i
			4'd8:    c = 8'h74; // t
			4'd9:    c = 8'h6c; // l
			4'd10:   c = 8'h65; // e
			4'd11:   c = 8'h3d; // =
			4'd12:   c = 8'h27; // '
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[hdl/icy_parse.sv]
// icy_parse: next-state and result logic for one stream byte.
// Depends on icy_pkg. Purely combinational; registers live in the top level.

module icy_parse #(
	parameter int unsigned TITLE_MAX = 128,
	parameter int unsigned CW        = 7
) (
	input  icy_pkg::interval_t  interval,
	input  icy_pkg::state_t     st,
	input  logic [CW-1:0]       tcount,
	input  logic [7:0]          in_byte,
	output icy_pkg::state_t     st_next,
	output logic [CW-1:0]       tcount_next,
	output icy_pkg::step_out_t  step
);

	localparam logic [CW-1:0] TitleLimit = CW'(TITLE_MAX - 1);
	localparam logic [icy_pkg::MatchWidth-1:0] KeyLenM = icy_pkg::MatchWidth'(icy_pkg::KeyLen);

	typedef struct packed {
		icy_pkg::state_t    st;
		logic [CW-1:0]      tc;
		icy_pkg::step_out_t so;
	} work_t;

	function automatic work_t f_push(input work_t w, input icy_pkg::kind_t k,
			input logic [7:0] d);
		work_t r;
		r = w;
		if (r.so.count != 2'd3) begin
			r.so.res[r.so.count].kind = k;
			r.so.res[r.so.count].data = d;
			r.so.count = r.so.count + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t f_finish(input work_t w);
		work_t r;
		r = f_push(w, icy_pkg::K_MARK, icy_pkg::ChNul);
		r.st.title_phase   = icy_pkg::TP_DONE;
		r.st.quote_pending = 1'b0;
		return r;
	endfunction

	function automatic work_t f_put(input work_t w, input logic [7:0] c);
		work_t r;
		r = f_push(w, icy_pkg::K_TITLE, c);
		r.tc = r.tc + CW'(1);
		if (r.tc >= TitleLimit)
			r = f_finish(r);
		return r;
	endfunction

	// Length byte: zero restarts the audio run, otherwise open a block of L*16 bytes
	function automatic work_t f_length(input work_t w, input logic [7:0] b,
			input icy_pkg::interval_t iv);
		work_t r;
		r = w;
		if (b == icy_pkg::ChNul) begin
			r.st.audio_countdown = iv;
			r.st.phase           = icy_pkg::PH_AUDIO;
		end else begin
			r.st.meta_remaining = {b, 4'b0000};
			r.st.match_index    = '0;
			r.st.title_phase    = icy_pkg::TP_SEARCH;
			r.st.quote_pending  = 1'b0;
			r.tc                = '0;
			r.st.phase          = icy_pkg::PH_META;
		end
		return r;
	endfunction

	function automatic work_t f_audio(input work_t w, input logic [7:0] b);
		work_t r;
		r = f_push(w, icy_pkg::K_AUDIO, b);
		r.st.audio_countdown = r.st.audio_countdown - icy_pkg::IntervalWidth'(1);
		r.st.phase = (r.st.audio_countdown == '0) ? icy_pkg::PH_LENGTH : icy_pkg::PH_AUDIO;
		return r;
	endfunction

	work_t                             w;
	logic [icy_pkg::MatchWidth-1:0]    m;
	logic                              halt;

	always_comb begin
		w.st       = st;
		w.tc       = tcount;
		w.so.res   = '0;
		w.so.count = 2'd0;
		m          = '0;
		halt       = 1'b0;

		if (interval == '0) begin
			w = f_push(w, icy_pkg::K_AUDIO, in_byte);
		end else begin
			case (st.phase)
				icy_pkg::PH_META: begin
					if (st.title_phase == icy_pkg::TP_SEARCH) begin
						m = st.match_index;
						if (m >= KeyLenM)
							m = '0;
						if (in_byte == icy_pkg::ChNul) begin
							w.st.title_phase = icy_pkg::TP_DONE;
						end else if (in_byte == icy_pkg::key_char(m)) begin
							m = m + icy_pkg::MatchWidth'(1);
							w.st.match_index = m;
							if (m == KeyLenM) begin
								w.st.title_phase   = icy_pkg::TP_EMIT;
								w.tc               = '0;
								w.st.quote_pending = 1'b0;
							end
						end else begin
							w.st.match_index = (in_byte == icy_pkg::ChS) ? 4'd1 : 4'd0;
						end
					end else if (st.title_phase == icy_pkg::TP_EMIT) begin
						// a held quote closes the title on ';', else it is a character
						if (st.quote_pending) begin
							w.st.quote_pending = 1'b0;
							if (in_byte == icy_pkg::ChSemi) begin
								w    = f_finish(w);
								halt = 1'b1;
							end else begin
								w = f_put(w, icy_pkg::ChQuote);
								if (w.st.title_phase != icy_pkg::TP_EMIT)
									halt = 1'b1;
							end
						end
						if (!halt) begin
							if (in_byte == icy_pkg::ChNul)
								w = f_finish(w);
							else if (in_byte == icy_pkg::ChQuote)
								w.st.quote_pending = 1'b1;
							else
								w = f_put(w, in_byte);
						end
					end
					w.st.meta_remaining = w.st.meta_remaining - icy_pkg::RemainWidth'(1);
					if (w.st.meta_remaining == '0) begin
						// block end: flush a held quote, then close an open title
						if (w.st.title_phase == icy_pkg::TP_EMIT) begin
							if (w.st.quote_pending) begin
								w.st.quote_pending = 1'b0;
								w = f_put(w, icy_pkg::ChQuote);
							end
							if (w.st.title_phase == icy_pkg::TP_EMIT)
								w = f_finish(w);
						end
						w.st.audio_countdown = interval;
						w.st.phase           = icy_pkg::PH_AUDIO;
					end
				end
				icy_pkg::PH_LENGTH: begin
					w = f_length(w, in_byte, interval);
				end
				default: begin
					if (st.audio_countdown == '0)
						w = f_length(w, in_byte, interval);
					else
						w = f_audio(w, in_byte);
				end
			endcase
		end
	end

	assign st_next     = w.st;
	assign tcount_next = w.tc;
	assign step        = w.so;

endmodule

[hdl/icy_metadata_demux_top.sv]
// icy_metadata_demux_top: ICY interleaved stream demux, top level.
// Depends on icy_pkg and icy_parse.

// One stream byte is taken per transfer on the input channel and split into audio
// bytes, title characters and a title-complete marker on the output channel. With
// meta_interval at zero every byte passes through as audio. Otherwise meta_interval
// audio bytes pass, a length byte L follows and then L*16 metadata bytes, in which
// the text after StreamTitle=' is emitted up to ';, a NUL, the block end or
// TITLE_MAX-1 characters, closed by a marker. Each byte is decoded in the cycle it
// is accepted and its zero to three results land in a three-entry result register
// that drains one result per output transfer. After an input byte giving at most one
// result the next byte can be taken in the next cycle unless the output stalls; a byte
// giving more results stalls the input while the single output port drains the
// result register. The next byte is taken in the same cycle as the last result of
// the previous one leaves. Bytes giving no result (length and most metadata bytes)
// never stall the input. Write meta_interval only while no results are pending; a
// write reloads the audio countdown and clears the title scanner.

module icy_metadata_demux_top #(
	parameter int unsigned TITLE_MAX = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	// stream byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	localparam int unsigned CW = $clog2(TITLE_MAX);

	icy_pkg::interval_t interval_q;
	icy_pkg::state_t    state_q;
	logic [CW-1:0]      tcount_q;

	icy_pkg::state_t    state_next;
	logic [CW-1:0]      tcount_next;
	icy_pkg::step_out_t step;

	icy_pkg::result_t [2:0] res_s1;
	logic [1:0]             cnt_q;

	logic in_xfer;
	logic out_xfer;

	// Take a byte when the result register is empty or its last result leaves now
	assign in_stall = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && out_stall);
	assign in_xfer  = in_valid && !in_stall;

	assign out_valid   = (cnt_q != 2'd0);
	assign out_xfer    = out_valid && !out_stall;
	assign out_kind    = res_s1[0].kind;
	assign out_byte    = res_s1[0].data;
	assign last_of_run = (cnt_q == 2'd1);

	icy_parse #(
		.TITLE_MAX (TITLE_MAX),
		.CW        (CW)
	) u_parse (
		.interval    (interval_q),
		.st          (state_q),
		.tcount      (tcount_q),
		.in_byte     (in_byte),
		.st_next     (state_next),
		.tcount_next (tcount_next),
		.step        (step)
	);

	// Demux state: a configuration write reloads the countdown and clears the scanner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q                    <= '0;
			state_q.audio_countdown       <= '0;
			state_q.phase                 <= icy_pkg::PH_AUDIO;
			state_q.meta_remaining        <= '0;
			state_q.match_index           <= '0;
			state_q.title_phase           <= icy_pkg::TP_SEARCH;
			state_q.quote_pending         <= 1'b0;
			tcount_q                      <= '0;
		end else if (cfg_wr_en) begin
			interval_q                    <= cfg_wr_data;
			state_q.audio_countdown       <= cfg_wr_data;
			state_q.phase                 <= icy_pkg::PH_AUDIO;
			state_q.meta_remaining        <= '0;
			state_q.match_index           <= '0;
			state_q.title_phase           <= icy_pkg::TP_SEARCH;
			state_q.quote_pending         <= 1'b0;
			tcount_q                      <= '0;
		end else if (in_xfer) begin
			state_q  <= state_next;
			tcount_q <= tcount_next;
		end
	end

	// Result count: load on a new byte, count down on each output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_xfer) begin
			cnt_q <= step.count;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result register: entry 0 is on the port; advance the rest on a transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_s1 <= step.res;
		end else if (out_xfer) begin
			res_s1[0] <= res_s1[1];
			res_s1[1] <= res_s1[2];
		end
	end

endmodule

[hdl/icy_checker.sv]
// icy_checker: port-level assertions (icy_port_assert) for icy_metadata_demux_top,
// with its bind. Depends on icy_pkg.

module icy_port_assert (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// More results of the same byte follow straight after a non-final transfer
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("result run broken before its last result");

	// No new byte is taken while more than one result of the current one is pending
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> in_stall)
		else $error("input taken while a result run is unfinished");

	// An audio byte is always the only result of its input byte
	a_audio_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == icy_pkg::K_AUDIO) |-> last_of_run)
		else $error("audio result not last of its run");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
			&& $stable(last_of_run))
		else $error("stalled result changed");

endmodule

bind icy_metadata_demux_top icy_port_assert u_icy_port_assert (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_kind    (out_kind),
	.out_byte    (out_byte),
	.last_of_run (last_of_run)
);
